// ----- rtl/twcw_pkg.sv -----
// ============================================================================
// twcw_pkg - shared types and constants of the text window character writer
// Command and register codes, the queued operation, configuration and result
// records, and the back-end sequencer states.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package twcw_pkg;

    localparam int IDX_W       = 16;    // holds any window cell index
    localparam int CELL_W      = 24;    // colour, attribute, character
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] CFG_WIN_LEFT   = 3'd0;
    localparam logic [2:0] CFG_WIN_TOP    = 3'd1;
    localparam logic [2:0] CFG_WIN_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_WIN_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_LINE_PITCH = 3'd4;
    localparam logic [2:0] CFG_CUR_ATTR   = 3'd5;
    localparam logic [2:0] CFG_CUR_COLOR  = 3'd6;
    localparam logic [2:0] CFG_FILL_CHAR  = 3'd7;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;

    typedef enum logic [2:0] {
        OP_CHAR,
        OP_NEWLINE,
        OP_SET,
        OP_READ,
        OP_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  ch;
        logic [7:0]  ncol;
        logic [4:0]  nrow;
        logic [11:0] addr;
    } op_t;

    typedef struct packed {
        logic [6:0] win_left;
        logic [4:0] win_top;
        logic [7:0] win_width;
        logic [5:0] win_height;
        logic [7:0] line_pitch;
        logic [7:0] cur_attr;
        logic [7:0] cur_color;
        logic [7:0] fill_char;
    } cfg_t;

    typedef struct packed {
        logic [7:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [7:0] cell_color;
    } res_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PREP,
        ST_BODY,
        ST_EMIT,
        ST_SC_RD,
        ST_SC_WR,
        ST_SC_FILL
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/twcw_ram.sv -----
// ============================================================================
// twcw_ram - generic single write, single read RAM
// One write port and one read port; read data is registered and holds while
// no read is issued.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twcw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/twcw_fifo.sv -----
// ============================================================================
// twcw_fifo - short operation queue between front end and back end
// Holds classified operations so that intake and execution stall apart.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twcw_fifo
    import twcw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire op_t  push_op,
    input  wire logic pop,
    output op_t       head,
    output logic      full,
    output logic      empty
);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/twcw_front.sv -----
// ============================================================================
// twcw_front - input intake and command classification
// Takes items from the input channel, sorts them into operations and pushes
// them into the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twcw_front
    import twcw_pkg::*;
(
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  new_col,
    input  wire logic [4:0]  new_row,
    input  wire logic [11:0] cell_addr,
    input  wire logic        queue_full,
    input  wire logic        clearing,
    output logic             push,
    output op_t              push_op
);

    assign in_stall = queue_full || clearing;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        push_op.ch   = char_code;
        push_op.ncol = new_col;
        push_op.nrow = new_row;
        push_op.addr = cell_addr;
        unique case (cmd)
            CMD_PUT:
            begin
                if (char_code == NEWLINE_CODE)
                begin
                    push_op.kind = OP_NEWLINE;
                end
                else
                begin
                    push_op.kind = OP_CHAR;
                    // control codes show as a space
                    if (char_code < SPACE_CODE)
                    begin
                        push_op.ch = SPACE_CODE;
                    end
                end
            end
            CMD_SET:  push_op.kind = OP_SET;
            CMD_READ: push_op.kind = OP_READ;
            default:  push_op.kind = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/twcw_back.sv -----
// ============================================================================
// twcw_back - operation sequencer over the cell store
// Keeps the cursor, writes cells, runs the scroll copy and fill, clears the
// store after reset and holds the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module twcw_back
    import twcw_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire op_t  q_head,
    input  wire logic q_empty,
    output logic      q_pop,
    output logic      clearing,
    output logic      out_valid,
    input  wire logic out_stall,
    output res_t      out_res
);

    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW          = $clog2(STORE_CELLS);

    back_state_t state_reg, state_next;
    back_state_t ret_reg, ret_next;
    logic [7:0]  col_reg, col_next;
    logic [4:0]  line_reg, line_next;
    op_t         op_reg, op_next;
    logic        scr_reg, scr_next;
    logic [7:0]  sc_col_reg, sc_col_next;
    logic [5:0]  sc_row_reg, sc_row_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic        oob_reg, oob_next;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg, out_next;

    logic [7:0]  eff_w;
    logic [5:0]  eff_h;
    logic        out_free, col_full, line_adv, h_multi, sc_last_col, sc_more2;
    logic        clr_last, slow_start;
    logic [7:0]  ix_col;
    logic [5:0]  ix_row;
    logic [6:0]  rowsum;
    logic [14:0] prod;
    logic [IDX_W-1:0] ix;
    logic        ix_in, rd_in;
    logic [15:0] attr_bits;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    logic              emit, emit_scr;
    logic [CELL_W-1:0] emit_cell;

    // zero width or height behaves as one
    assign eff_w = (cfg.win_width == 8'd0) ? 8'd1 : cfg.win_width;
    assign eff_h = (cfg.win_height == 6'd0) ? 6'd1 : cfg.win_height;

    assign out_free    = !out_valid_reg || !out_stall;
    assign col_full    = (col_reg >= eff_w);
    assign line_adv    = (({1'b0, line_reg} + 6'd1) < eff_h);
    assign h_multi     = (eff_h != 6'd1);
    assign sc_last_col = (sc_col_reg == (eff_w - 8'd1));
    assign sc_more2    = (({1'b0, sc_row_reg} + 7'd2) < {1'b0, eff_h});
    assign clr_last    = (clr_reg == AW'(STORE_CELLS - 1));
    assign slow_start  = col_full || (q_head.kind == OP_NEWLINE && !line_adv);
    assign attr_bits   = {cfg.cur_color, cfg.cur_attr};
    assign clearing    = (state_reg == ST_CLEAR);

    // shared cell index unit
    always_comb
    begin
        unique case (state_reg)
            ST_SC_RD:
            begin
                ix_col = sc_col_reg;
                ix_row = sc_row_reg + 6'd1;
            end
            ST_SC_WR:
            begin
                ix_col = sc_col_reg;
                ix_row = sc_row_reg;
            end
            ST_SC_FILL:
            begin
                ix_col = sc_col_reg;
                ix_row = eff_h - 6'd1;
            end
            default:
            begin
                ix_col = col_reg;
                ix_row = {1'b0, line_reg};
            end
        endcase
    end

    assign rowsum = {2'b00, cfg.win_top} + {1'b0, ix_row};
    assign prod   = {8'd0, rowsum} * {7'd0, cfg.line_pitch};
    assign ix     = IDX_W'(prod) + IDX_W'(cfg.win_left) + IDX_W'(ix_col);
    assign ix_in  = (ix < IDX_W'(STORE_CELLS));
    assign rd_in  = (IDX_W'(q_head.addr) < IDX_W'(STORE_CELLS));

    twcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (STORE_CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin : next_state
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.kind)
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        OP_CHAR, OP_NEWLINE:
                        begin
                            if (slow_start)
                            begin
                                state_next = ST_PREP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ, ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PREP:
            begin
                if (col_full && !line_adv)
                begin
                    ret_next   = ST_BODY;
                    state_next = h_multi ? ST_SC_RD : ST_SC_FILL;
                end
                else
                begin
                    state_next = ST_BODY;
                end
            end
            ST_BODY:
            begin
                if (op_reg.kind == OP_NEWLINE && !line_adv)
                begin
                    ret_next   = ST_EMIT;
                    state_next = h_multi ? ST_SC_RD : ST_SC_FILL;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SC_RD:
            begin
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                if (sc_last_col && !sc_more2)
                begin
                    state_next = ST_SC_FILL;
                end
                else
                begin
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_FILL:
            begin
                if (sc_last_col)
                begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin : datapath
        col_next    = col_reg;
        line_next   = line_reg;
        op_next     = op_reg;
        scr_next    = scr_reg;
        sc_col_next = sc_col_reg;
        sc_row_next = sc_row_reg;
        clr_next    = clr_reg;
        oob_next    = oob_reg;
        ram_we      = 1'b0;
        ram_waddr   = ix[AW-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = ix[AW-1:0];
        q_pop       = 1'b0;
        emit        = 1'b0;
        emit_scr    = 1'b0;
        emit_cell   = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_head.kind)
                        OP_READ:
                        begin
                            q_pop     = 1'b1;
                            ram_re    = 1'b1;
                            ram_raddr = AW'(IDX_W'(q_head.addr));
                            oob_next  = !rd_in;
                        end
                        OP_CHAR, OP_NEWLINE:
                        begin
                            if (slow_start)
                            begin
                                q_pop    = 1'b1;
                                op_next  = q_head;
                                scr_next = 1'b0;
                            end
                            else if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                                if (q_head.kind == OP_CHAR)
                                begin
                                    ram_we    = ix_in;
                                    ram_wdata = {attr_bits, q_head.ch};
                                    col_next  = col_reg + 8'd1;
                                end
                                else
                                begin
                                    col_next  = 8'd0;
                                    line_next = line_reg + 5'd1;
                                end
                            end
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                q_pop = 1'b1;
                                emit  = 1'b1;
                                if (q_head.kind == OP_SET)
                                begin
                                    col_next  = q_head.ncol;
                                    line_next = q_head.nrow;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_cell = oob_reg ? '0 : ram_rdata;
                end
            end
            ST_PREP:
            begin
                // wrap on a full line before the character is handled
                if (col_full)
                begin
                    col_next = 8'd0;
                    if (line_adv)
                    begin
                        line_next = line_reg + 5'd1;
                    end
                    else
                    begin
                        scr_next    = 1'b1;
                        sc_col_next = 8'd0;
                        sc_row_next = 6'd0;
                    end
                end
            end
            ST_BODY:
            begin
                if (op_reg.kind == OP_NEWLINE)
                begin
                    col_next = 8'd0;
                    if (line_adv)
                    begin
                        line_next = line_reg + 5'd1;
                    end
                    else
                    begin
                        scr_next    = 1'b1;
                        sc_col_next = 8'd0;
                        sc_row_next = 6'd0;
                    end
                end
                else
                begin
                    ram_we    = ix_in;
                    ram_wdata = {attr_bits, op_reg.ch};
                    col_next  = col_reg + 8'd1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    emit_scr = scr_reg;
                end
            end
            ST_SC_RD:
            begin
                ram_re   = 1'b1;
                oob_next = !ix_in;
            end
            ST_SC_WR:
            begin
                ram_we    = ix_in;
                ram_wdata = oob_reg ? '0 : ram_rdata;
                if (sc_last_col)
                begin
                    sc_col_next = 8'd0;
                    sc_row_next = sc_row_reg + 6'd1;
                end
                else
                begin
                    sc_col_next = sc_col_reg + 8'd1;
                end
            end
            ST_SC_FILL:
            begin
                ram_we    = ix_in;
                ram_wdata = {attr_bits, cfg.fill_char};
                sc_col_next = sc_last_col ? 8'd0 : sc_col_reg + 8'd1;
            end
            default:
            begin
            end
        endcase

        out_valid_next = emit || (out_valid_reg && out_stall);
        out_next       = out_reg;
        if (emit)
        begin
            out_next.cursor_col = col_next;
            out_next.cursor_row = line_next;
            out_next.scrolled   = emit_scr;
            out_next.cell_char  = emit_cell[7:0];
            out_next.cell_attr  = emit_cell[15:8];
            out_next.cell_color = emit_cell[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ret_reg       <= ST_EMIT;
            col_reg       <= 8'd0;
            line_reg      <= 5'd0;
            scr_reg       <= 1'b0;
            sc_col_reg    <= 8'd0;
            sc_row_reg    <= 6'd0;
            clr_reg       <= '0;
            oob_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            col_reg       <= col_next;
            line_reg      <= line_next;
            scr_reg       <= scr_next;
            sc_col_reg    <= sc_col_next;
            sc_row_reg    <= sc_row_next;
            clr_reg       <= clr_next;
            oob_reg       <= oob_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef NO_ASSERTIONS
    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !q_pop)
        else $error("queue popped during clearing pass");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != ST_CLEAR) |-> ix_in)
        else $error("cell write outside store");

    a_copy_row_exists: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_WR) |-> (({1'b0, sc_row_reg} + 7'd1) < {1'b0, eff_h}))
        else $error("scroll copy past last row");

    a_read_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SC_RD) |=> (state_reg == ST_SC_WR))
        else $error("scroll read not followed by its write");

    a_body_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BODY && op_reg.kind == OP_CHAR) |-> !col_full)
        else $error("character written on a full line");
`endif

endmodule

`default_nettype wire

// ----- rtl/text_window_char_writer_core.sv -----
// ============================================================================
// text_window_char_writer_core - text window character writer
// Configuration registers, operation queue and sequencer over the cell store.
// ============================================================================
// Input channel (in_valid/in_stall): cmd with char_code, new_col, new_row and
// cell_addr. Output channel (out_valid/out_stall): one result per item with
// the cursor, the scroll flag and, for read_cell, the cell contents.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects one of the
// eight window registers, cfg_data is written; cfg_ready is always high.
// Flow: an ordinary character, newline without scroll, set_cursor or an
// unknown command passes through the queue and the result register, one item
// per cycle while out_stall is low; read_cell also passes through the
// registered read port of the store, and the next item waits for its result.
// A character or newline on a full line, or a newline on the last row, passes
// through the PREP, BODY and EMIT states with any scroll between. A scroll
// copies w*(h-1) cells, each read then written through the single store port
// pair, and fills w cells at one per cycle, w and h being the window size.
// After reset all MAX_COLS*MAX_ROWS store cells (4096 by default) are cleared
// one cell a cycle, with in_stall high; configuration writes are still taken.
// While a result waits on out_stall, the result register holds and the
// sequencer keeps at most one item; the two-entry queue fills, in_stall rises.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module text_window_char_writer_core
    import twcw_pkg::*;
#(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic [7:0]  new_col,
    input  wire logic [4:0]  new_row,
    input  wire logic [11:0] cell_addr,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       cursor_col,
    output logic [4:0]       cursor_row,
    output logic             scrolled,
    output logic [7:0]       cell_char,
    output logic [7:0]       cell_attr,
    output logic [7:0]       cell_color,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    cfg_t cfg_reg;
    op_t  push_op, q_head;
    logic push, q_pop, q_full, q_empty, clearing;
    res_t out_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_left   <= 7'd0;
            cfg_reg.win_top    <= 5'd0;
            cfg_reg.win_width  <= 8'd80;
            cfg_reg.win_height <= 6'd24;
            cfg_reg.line_pitch <= 8'd80;
            cfg_reg.cur_attr   <= 8'd0;
            cfg_reg.cur_color  <= 8'd7;
            cfg_reg.fill_char  <= 8'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIN_LEFT:   cfg_reg.win_left   <= cfg_data[6:0];
                CFG_WIN_TOP:    cfg_reg.win_top    <= cfg_data[4:0];
                CFG_WIN_WIDTH:  cfg_reg.win_width  <= cfg_data;
                CFG_WIN_HEIGHT: cfg_reg.win_height <= cfg_data[5:0];
                CFG_LINE_PITCH: cfg_reg.line_pitch <= cfg_data;
                CFG_CUR_ATTR:   cfg_reg.cur_attr   <= cfg_data;
                CFG_CUR_COLOR:  cfg_reg.cur_color  <= cfg_data;
                CFG_FILL_CHAR:  cfg_reg.fill_char  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    twcw_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_code  (char_code),
        .new_col    (new_col),
        .new_row    (new_row),
        .cell_addr  (cell_addr),
        .queue_full (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_op    (push_op)
    );

    twcw_fifo u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    twcw_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign cursor_col = out_res.cursor_col;
    assign cursor_row = out_res.cursor_row;
    assign scrolled   = out_res.scrolled;
    assign cell_char  = out_res.cell_char;
    assign cell_attr  = out_res.cell_attr;
    assign cell_color = out_res.cell_color;

endmodule

`default_nettype wire
